FILE: rtl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg
// shared constants, types and aes helpers for the miyaguchi-preneel hash
// ----------------------------------------------------------------------------
package mpc_pkg;

    localparam int unsigned LEN_FIELD_BYTES = 5;
    localparam int unsigned BLK_BYTES       = 16;
    localparam int unsigned TOTAL_W         = 38;
    localparam int unsigned BITS_W          = TOTAL_W + 4;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef logic [127:0] t_block;

    typedef struct packed {
        logic   start;
        t_block key;
        t_block msg;
    } t_aes_req;

    typedef struct packed {
        logic   done;
        t_block chain;
    } t_aes_rsp;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits 127-8i
    function automatic logic [7:0] get_byte(input t_block b, input int unsigned i);
        get_byte = b[127-8*i -: 8];
    endfunction

endpackage

FILE: rtl/mpc_round.sv
// ----------------------------------------------------------------------------
// mpc_round
// iterative aes-128 unit, one round and one key step per cycle, with the
// miyaguchi-preneel feed-forward applied after the last round
// ----------------------------------------------------------------------------
module mpc_round (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mpc_pkg::t_aes_req i_req,
    output mpc_pkg::t_aes_rsp o_rsp
);

    logic          r_busy, n_busy;
    logic [3:0]    r_rnd, n_rnd;
    logic [7:0]    r_rcon, n_rcon;
    mpc_pkg::t_block r_st, n_st, r_rk, n_rk, r_key, n_key, r_msg, n_msg;
    logic          r_done, n_done;

    mpc_pkg::t_block w_t, w_mc, w_rk;

    always_comb begin
        logic [7:0] a0, a1, a2, a3, al;
        for (int i = 0; i < 16; i++) begin
            w_t[127-8*i -: 8] = mpc_pkg::SBOX[mpc_pkg::get_byte(r_st, (i + 4*(i & 3)) & 15)];
        end
        for (int c = 0; c < 4; c++) begin
            a0 = w_t[127-32*c -: 8];
            a1 = w_t[119-32*c -: 8];
            a2 = w_t[111-32*c -: 8];
            a3 = w_t[103-32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            w_mc[127-32*c -: 8] = a0 ^ al ^ mpc_pkg::xt(a0 ^ a1);
            w_mc[119-32*c -: 8] = a1 ^ al ^ mpc_pkg::xt(a1 ^ a2);
            w_mc[111-32*c -: 8] = a2 ^ al ^ mpc_pkg::xt(a2 ^ a3);
            w_mc[103-32*c -: 8] = a3 ^ al ^ mpc_pkg::xt(a3 ^ a0);
        end
        w_rk[127:120] = r_rk[127:120] ^ mpc_pkg::SBOX[r_rk[23:16]] ^ r_rcon;
        w_rk[119:112] = r_rk[119:112] ^ mpc_pkg::SBOX[r_rk[15:8]];
        w_rk[111:104] = r_rk[111:104] ^ mpc_pkg::SBOX[r_rk[7:0]];
        w_rk[103:96]  = r_rk[103:96]  ^ mpc_pkg::SBOX[r_rk[31:24]];
        for (int i = 4; i < 16; i++) begin
            w_rk[127-8*i -: 8] = r_rk[127-8*i -: 8] ^ w_rk[127-8*(i-4) -: 8];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_rnd  = r_rnd;
        n_rcon = r_rcon;
        n_st   = r_st;
        n_rk   = r_rk;
        n_key  = r_key;
        n_msg  = r_msg;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_rnd  = 4'd1;
            n_rcon = 8'h01;
            n_st   = i_req.msg ^ i_req.key;
            n_rk   = i_req.key;
            n_key  = i_req.key;
            n_msg  = i_req.msg;
        end else if (r_busy) begin
            n_rk   = w_rk;
            n_rcon = mpc_pkg::xt(r_rcon);
            n_rnd  = r_rnd + 4'd1;
            if (r_rnd == 4'd10) begin
                n_st   = (w_t ^ w_rk) ^ r_msg ^ r_key;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_st = w_mc ^ w_rk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_rnd  <= n_rnd;
        end
        r_rcon <= n_rcon;
        r_st   <= n_st;
        r_rk   <= n_rk;
        r_key  <= n_key;
        r_msg  <= n_msg;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.chain = r_st;

endmodule

FILE: rtl/mp_aes128_compression.sv
// ----------------------------------------------------------------------------
// mp_aes128_compression
// miyaguchi-preneel hash over aes-128 with length padding
// each compression in the shared round unit has one step to load, ten rounds
// and one step to take the result; a last word runs one or two compressions
// before its digest is valid, and an oversized length skips them with the
// error word valid next cycle
// a word is taken only in the idle state, not while a compression or digest is pending
// reset: synchronous active-low, clears chaining value, byte total and control
// ----------------------------------------------------------------------------
module mp_aes128_compression (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // data_hi, data_lo, byte_count(5), pad(3)
    input  logic         s_axis_tlast,   // last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // digest_hi, digest_lo
    output logic         m_axis_tuser    // error
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_NEXT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    mpc_pkg::t_block r_h, n_h, r_blk, n_blk, r_blk2, n_blk2;
    logic [mpc_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [1:0] r_left, n_left;
    logic       r_err, n_err;
    logic       r_last;

    mpc_pkg::t_aes_req w_req;
    mpc_pkg::t_aes_rsp w_rsp;

    logic [4:0]  w_cnt;
    logic [mpc_pkg::BITS_W-1:0] w_bits;
    logic [mpc_pkg::TOTAL_W:0]  w_sum;
    mpc_pkg::t_block w_in, w_pad, w_len, w_padz;
    logic w_acc;

    mpc_round u_round (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // block byte 0 is the top byte of data_hi
    assign w_in  = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_cnt = (s_axis_tdata[132:128] > 5'd16) ? 5'd16 : s_axis_tdata[132:128];
    assign w_sum = {1'b0, r_total} + {{(mpc_pkg::TOTAL_W-4){1'b0}}, w_cnt};
    assign w_bits = {w_sum[mpc_pkg::TOTAL_W:0], 3'b000};

    // padding block and length block
    always_comb begin
        logic [mpc_pkg::BITS_W-1:0] b;
        b = w_bits;
        for (int i = 0; i < 16; i++) begin
            if (w_cnt == 5'd16) begin
                w_pad[127-8*i -: 8] = (i == 0) ? mpc_pkg::PAD_BYTE : 8'h00;
            end else if (i < w_cnt) begin
                w_pad[127-8*i -: 8] = w_in[127-8*i -: 8];
            end else if (i == w_cnt) begin
                w_pad[127-8*i -: 8] = mpc_pkg::PAD_BYTE;
            end else begin
                w_pad[127-8*i -: 8] = 8'h00;
            end
        end
        w_padz = '0;
        for (int i = 0; i < mpc_pkg::LEN_FIELD_BYTES; i++) begin
            w_padz[8*i +: 8] = 8'(b >> (8*i)) & mpc_pkg::BYTE_MASK;
        end
        w_len = w_pad;
        for (int i = 0; i < mpc_pkg::LEN_FIELD_BYTES; i++) begin
            w_len[8*i +: 8] = w_padz[8*i +: 8];
        end
    end

    always_comb begin
        logic [4:0] room;
        n_state = r_state;
        n_h     = r_h;
        n_blk   = r_blk;
        n_blk2  = r_blk2;
        n_total = r_total;
        n_left  = r_left;
        n_err   = r_err;
        w_req.start = 1'b0;
        w_req.key   = r_h;
        w_req.msg   = r_blk;
        room = (w_cnt == 5'd16) ? 5'd16 : 5'd16 - w_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (!s_axis_tlast) begin
                        n_blk   = w_in;
                        n_left  = 2'd1;
                        n_total = (r_total >= mpc_pkg::TOTAL_MAX - 38'd16) ?
                                  mpc_pkg::TOTAL_MAX : r_total + 38'd16;
                        n_state = S_NEXT;
                    end else if ((w_bits >> (8*mpc_pkg::LEN_FIELD_BYTES)) != '0) begin
                        n_err   = 1'b1;
                        n_h     = '0;
                        n_state = S_OUT;
                    end else begin
                        n_err = 1'b0;
                        if (w_cnt == 5'd16) begin
                            n_blk  = w_in;
                            n_blk2 = {w_pad[127:8*mpc_pkg::LEN_FIELD_BYTES],
                                      w_padz[8*mpc_pkg::LEN_FIELD_BYTES-1:0]};
                            n_left = 2'd2;
                        end else if (room < 5'(mpc_pkg::LEN_FIELD_BYTES + 1)) begin
                            n_blk  = w_pad;
                            n_blk2 = w_padz;
                            n_left = 2'd2;
                        end else begin
                            n_blk  = w_len;
                            n_left = 2'd1;
                        end
                        n_state = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                w_req.start = 1'b1;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (w_rsp.done) begin
                    n_h    = w_rsp.chain;
                    n_left = r_left - 2'd1;
                    if (r_left == 2'd2) begin
                        n_blk   = r_blk2;
                        n_state = S_NEXT;
                    end else if (r_last) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_h     = '0;
                    n_total = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_h     <= '0;
            r_total <= '0;
            r_left  <= '0;
            r_last  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_total <= n_total;
            r_left  <= n_left;
            r_err   <= n_err;
            if (w_acc) begin
                r_last <= s_axis_tlast;
            end
        end
        r_blk  <= n_blk;
        r_blk2 <= n_blk2;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_h[63:0], r_h[127:64]};
    assign m_axis_tuser  = r_err;

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the miyaguchi-preneel aes-128 hash. words are sent
// on the slave stream, and a local predictor computes the digest of each
// message. a checker compares every digest and error flag in order. both
// sides stall at random outside the back-to-back test.
// ----------------------------------------------------------------------------
module testbench;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // data_hi, data_lo, byte_count(5), pad(3)
    logic         s_axis_tlast;   // last
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // digest_hi, digest_lo
    logic         m_axis_tuser;   // error

    typedef struct packed {
        logic [63:0] digest_hi;
        logic [63:0] digest_lo;
        logic        error;
    } t_digest;

    t_digest     digest_q[$];
    logic [127:0] chain_h;
    logic [37:0]  msg_bytes;
    int          fails;
    int          words_sent;
    int          digests_seen;
    int          cycles;
    logic        no_idle;

    mp_aes128_compression dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        gf_double = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // aes-128 encryption, byte i at bits 127-8i
    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] pt);
        logic [7:0] rk[16], st[16], sb[16];
        logic [7:0] rcon, a0, a1, a2, a3, all;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127-8*i -: 8];
            st[i] = pt[127-8*i -: 8] ^ rk[i];
        end
        rcon = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) sb[i] = mpc_pkg::SBOX[st[(i + 4*(i%4)) % 16]];
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    sb[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                    sb[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    sb[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    sb[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
            end
            rk[0] = rk[0] ^ mpc_pkg::SBOX[rk[13]] ^ rcon;
            rk[1] = rk[1] ^ mpc_pkg::SBOX[rk[14]];
            rk[2] = rk[2] ^ mpc_pkg::SBOX[rk[15]];
            rk[3] = rk[3] ^ mpc_pkg::SBOX[rk[12]];
            for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
            rcon = gf_double(rcon);
            for (int i = 0; i < 16; i++) st[i] = sb[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++) aes_encrypt[127-8*i -: 8] = st[i];
    endfunction

    function automatic logic [127:0] mp_compress(input logic [127:0] h, input logic [127:0] m);
        mp_compress = aes_encrypt(h, m) ^ m ^ h;
    endfunction

    // update the running hash with one accepted word
    task automatic absorb_word(input logic [127:0] blk, input logic [4:0] bcnt,
                               input logic last);
        logic [41:0]  bits;
        logic [127:0] pad;
        logic [4:0]   cnt;
        t_digest      d;
        if (!last) begin
            chain_h = mp_compress(chain_h, blk);
            msg_bytes = (msg_bytes >= mpc_pkg::TOTAL_MAX - 38'd16) ?
                        mpc_pkg::TOTAL_MAX : msg_bytes + 38'd16;
        end else begin
            cnt = (bcnt > 5'd16) ? 5'd16 : bcnt;
            bits = ({4'd0, msg_bytes} + {37'd0, cnt}) << 3;
            if (bits[41:40] != 2'b00) begin
                d = '{digest_hi: '0, digest_lo: '0, error: 1'b1};
            end else begin
                if (cnt == 5'd16) begin
                    chain_h = mp_compress(chain_h, blk);
                    cnt = 5'd0;
                end
                pad = '0;
                for (int i = 0; i < 16; i++) begin
                    if (i < cnt) pad[127-8*i -: 8] = blk[127-8*i -: 8];
                    else if (i == cnt) pad[127-8*i -: 8] = mpc_pkg::PAD_BYTE;
                end
                if ((5'd16 - cnt) < 5'(mpc_pkg::LEN_FIELD_BYTES + 1)) begin
                    chain_h = mp_compress(chain_h, pad);
                    pad = '0;
                end
                pad[8*mpc_pkg::LEN_FIELD_BYTES-1:0] = bits[8*mpc_pkg::LEN_FIELD_BYTES-1:0];
                chain_h = mp_compress(chain_h, pad);
                d = '{digest_hi: chain_h[127:64], digest_lo: chain_h[63:0], error: 1'b0};
            end
            digest_q.push_back(d);
            chain_h = '0;
            msg_bytes = '0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic [127:0] blk, input logic [4:0] bcnt,
                             input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tdata  <= {3'b000, bcnt, blk[63:0], blk[127:64]};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_word(blk, bcnt, last);
        words_sent++;
    endtask

    task automatic send_message(input int nblk);
        logic [127:0] blk;
        logic [4:0]   bcnt;
        int           r;
        for (int b = 0; b < nblk; b++) begin
            blk = {$urandom, $urandom, $urandom, $urandom};
            bcnt = 5'($urandom_range(0, 31));
            if (b == nblk - 1) begin
                r = $urandom_range(0, 9);
                if (r < 8) bcnt = 5'($urandom_range(0, 16));
            end
            send_word(blk, bcnt, b == nblk - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_extremes();
        send_word('0, 5'd0, 1'b1);
        send_word('1, 5'd16, 1'b1);
        send_word('0, 5'd0, 1'b0);
        send_word('1, 5'd31, 1'b1);
        send_word({64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210}, 5'd10, 1'b1);
        send_word('1, 5'd11, 1'b1);
        send_word({8'h80, 120'd0}, 5'd3, 1'b0);
        send_word(128'd1, 5'd15, 1'b0);
        send_word({64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555}, 5'd15, 1'b1);
    endtask

    task automatic test_long_messages();
        send_message(12);
        wait_drained();
        send_message(20);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int n = 0; n < 10; n++) send_message($urandom_range(1, 3));
        no_idle = 1'b0;
    endtask

    task automatic test_random_messages();
        int r;
        while (words_sent < 750) begin
            r = $urandom_range(0, 99);
            if (r < 60) send_message($urandom_range(1, 3));
            else if (r < 90) send_message($urandom_range(4, 10));
            else send_message($urandom_range(11, 24));
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
    endtask

    // result side stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if (no_idle) m_axis_tready <= 1'b1;
        else m_axis_tready <= (pick_gap() == 0);
    end

    always @(posedge i_clk) begin
        t_digest d;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            digests_seen++;
            if (digest_q.size() == 0) begin
                $error("digest with none expected: %h", m_axis_tdata);
                fails++;
            end else begin
                d = digest_q.pop_front();
                if (m_axis_tdata[63:0] !== d.digest_hi) begin
                    $error("digest_hi expected %h actual %h", d.digest_hi, m_axis_tdata[63:0]);
                    fails++;
                end
                if (m_axis_tdata[127:64] !== d.digest_lo) begin
                    $error("digest_lo expected %h actual %h", d.digest_lo,
                           m_axis_tdata[127:64]);
                    fails++;
                end
                if (m_axis_tuser !== d.error) begin
                    $error("error expected %b actual %b", d.error, m_axis_tuser);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 500000) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        fails = 0;
        words_sent = 0;
        digests_seen = 0;
        cycles = 0;
        no_idle = 1'b0;
        chain_h = '0;
        msg_bytes = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        wait_drained();
        test_back_to_back();
        test_long_messages();
        test_random_messages();
        wait_drained();
        repeat (60) @(negedge i_clk);
        $display("sent %0d words, checked %0d digests", words_sent, digests_seen);
        $display("messages of 1 to 24 blocks, all tail byte counts, random stalls");
        if (fails == 0 && digest_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
